@@ hdl/qead_pkg.sv @@
// ----------------------------------------------------------------------------
// qead_pkg
// shared types and constants for the quadrature encoder decoder with
// detent acceleration
// ----------------------------------------------------------------------------
package qead_pkg;

   localparam int CfgWidth  = 16;
   localparam int StepWidth = 32;
   localparam int TimeWidth = 32;

   // register indexes on the csr port
   localparam logic [1:0] REG_ACCEL_GAIN      = 2'd0;
   localparam logic [1:0] REG_ACCEL_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_ACCEL_CAP       = 2'd2;

   // bit i set means transition code i is a legal gray step
   localparam logic [15:0] VALID_CODES = 16'h6996;

   // history patterns of a full detent
   localparam logic [15:0] PAT_CW_A  = 16'hE817;
   localparam logic [15:0] PAT_CW_B  = 16'h17E8;
   localparam logic [15:0] PAT_CCW_A = 16'hD42B;
   localparam logic [15:0] PAT_CCW_B = 16'h2BD4;

   localparam logic [StepWidth-1:0] STEP_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [CfgWidth-1:0] coeff;
      logic [CfgWidth-1:0] threshold;
      logic [CfgWidth-1:0] cap;
   } cfg_type;

   // one detent waiting for the back end
   typedef struct packed {
      logic                negative;
      logic                accel;
      logic [CfgWidth-1:0] dividend;
      logic [CfgWidth-1:0] divisor;
   } detent_type;

endpackage

@@ hdl/quadrature_encoder_accel_decoder.sv @@
// ----------------------------------------------------------------------------
// quadrature_encoder_accel_decoder
// quadrature encoder decoder with gray-code filtering and detent acceleration
//
//   channel  dir  beat
//   req      in   tdata: pin_a[0], pin_b[1], now_ms[33:2], zero pad [39:34]
//   rsp      out  tdata: step[31:0] signed
//   csr      in   addr 0 accel gain, 1 accel_threshold_ms, 2 accel_cap_ms
//
// a poll is classified combinationally as it is taken; polls are taken while the queue has room
// an accelerated detent passes the step unit as 16 divide steps, one multiply,
// a load and the output register; a plain detent goes straight to the load
// synchronous reset clears pin history, detent history, last-motion time
// and restores register defaults
// a stalled rsp holds its beat; the queue, the step unit and the output
// register absorb up to QUEUE_DEPTH + 2 detents before req_tready falls
// ----------------------------------------------------------------------------
module quadrature_encoder_accel_decoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pin_a, pin_b, now_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // step
   input  logic        csr_wen,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   qead_pkg::cfg_type    cfg_ff, cfg_in;
   qead_pkg::detent_type push_entry, pop_entry;
   logic                 accept, push, pop, full, empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_addr)
            qead_pkg::REG_ACCEL_GAIN:      cfg_in.coeff     = csr_wdata;
            qead_pkg::REG_ACCEL_THRESHOLD: cfg_in.threshold = csr_wdata;
            qead_pkg::REG_ACCEL_CAP:       cfg_in.cap       = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coeff     <= 16'd0;
         cfg_ff.threshold <= 16'd50;
         cfg_ff.cap       <= 16'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   qead_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .pin_a  (req_tdata[0]),
      .pin_b  (req_tdata[1]),
      .now_ms (req_tdata[33:2]),
      .push   (push),
      .entry  (push_entry)
   );

   qead_fifo #(
      .WIDTH ($bits(qead_pkg::detent_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .pop_data  (pop_entry),
      .full      (full),
      .empty     (empty)
   );

   qead_back u_back (
      .clock      (clock),
      .reset      (reset),
      .coeff      (cfg_ff.coeff),
      .q_empty    (empty),
      .q_data     (pop_entry),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ hdl/qead_fifo.sv @@
// ----------------------------------------------------------------------------
// qead_fifo
// small register queue between the classifier and the step unit
// ----------------------------------------------------------------------------
module qead_fifo #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == FullCnt);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue count above depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

endmodule

@@ hdl/qead_front.sv @@
// ----------------------------------------------------------------------------
// qead_front
// tracks the pin transitions, detects detents and times them
// ----------------------------------------------------------------------------
module qead_front (
   input  logic                          clock,
   input  logic                          reset,
   input  qead_pkg::cfg_type             cfg,
   input  logic                          accept,
   input  logic                          pin_a,
   input  logic                          pin_b,
   input  logic [qead_pkg::TimeWidth-1:0] now_ms,
   output logic                          push,
   output qead_pkg::detent_type          entry
);

   logic [3:0]                     code_ff, code_in;
   logic [15:0]                    hist_ff, hist_in;
   logic [qead_pkg::TimeWidth-1:0] last_ff, last_in;
   logic [qead_pkg::TimeWidth-1:0] elapsed;
   logic                           code_ok, is_detent, negative, accel_on, fast;
   logic [qead_pkg::CfgWidth-1:0]  divisor;

   assign code_in  = {code_ff[1:0], pin_a, pin_b};
   assign code_ok  = qead_pkg::VALID_CODES[code_in];
   assign hist_in  = {hist_ff[11:0], code_in};
   assign elapsed  = now_ms - last_ff;
   assign accel_on = (cfg.coeff != '0);
   assign fast     = (elapsed < {16'd0, cfg.threshold});

   always_comb begin
      is_detent = 1'b0;
      negative  = 1'b0;
      case (hist_in)
         qead_pkg::PAT_CW_A, qead_pkg::PAT_CW_B: begin
            is_detent = 1'b1;
         end
         qead_pkg::PAT_CCW_A, qead_pkg::PAT_CCW_B: begin
            is_detent = 1'b1;
            negative  = 1'b1;
         end
         default: begin
            is_detent = 1'b0;
         end
      endcase
   end

   // elapsed fits 16 bits whenever it is below the threshold
   always_comb begin
      divisor = (elapsed[15:0] > cfg.cap) ? elapsed[15:0] : cfg.cap;
      if (divisor == '0) begin
         divisor = 16'd1;
      end
   end

   assign push           = accept && code_ok && is_detent;
   assign entry.negative = negative;
   assign entry.accel    = accel_on && fast;
   assign entry.dividend = cfg.threshold;
   assign entry.divisor  = divisor;

   always_comb begin
      last_in = last_ff;
      if (push && accel_on) begin
         last_in = now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= '0;
         hist_ff <= '0;
         last_ff <= '0;
      end else begin
         if (accept) begin
            code_ff <= code_in;
         end
         if (accept && code_ok) begin
            hist_ff <= hist_in;
         end
         last_ff <= last_in;
      end
   end

   a_push_needs_valid: assert property (@(posedge clock) disable iff (reset)
      push |=> qead_pkg::VALID_CODES[code_ff])
      else $error("detent pushed on an illegal transition");

endmodule

@@ hdl/qead_back.sv @@
// ----------------------------------------------------------------------------
// qead_back
// step unit: serial divide and multiply by coefficient for an accelerated detent, unit step otherwise, saturate, sign
// ----------------------------------------------------------------------------
module qead_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [qead_pkg::CfgWidth-1:0]  coeff,
   input  logic                           q_empty,
   input  qead_pkg::detent_type           q_data,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [qead_pkg::StepWidth-1:0] rsp_tdata
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_MUL  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   logic [15:0]                    rem_ff, rem_in;
   logic [15:0]                    quo_ff, quo_in;
   logic [15:0]                    div_ff, div_in;
   logic [3:0]                     cnt_ff, cnt_in;
   logic                           neg_ff, neg_in;
   logic [qead_pkg::StepWidth-1:0] prod_ff, prod_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [qead_pkg::StepWidth-1:0] rsp_data_ff, rsp_data_in;
   logic [16:0]                    trial;
   logic [qead_pkg::StepWidth-1:0] mag;
   logic                           load_rsp;

   assign trial    = {rem_ff, quo_ff[15]} - {1'b0, div_ff};
   assign mag      = prod_ff[31] ? qead_pkg::STEP_MAX : prod_ff;
   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign q_pop    = (state_ff == S_IDLE) && !q_empty;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               neg_in = q_data.negative;
               rem_in = '0;
               quo_in = q_data.dividend;
               div_in = q_data.divisor;
               cnt_in = 4'd15;
               if (q_data.accel) begin
                  state_in = S_DIV;
               end else begin
                  prod_in  = 32'd1;
                  state_in = S_DONE;
               end
            end
         end
         S_DIV: begin
            if (!trial[16]) begin
               rem_in = trial[15:0];
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = {rem_ff[14:0], quo_ff[15]};
               quo_in = {quo_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = {16'd0, quo_ff} * {16'd0, coeff};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load_rsp) begin
               rsp_data_in  = neg_ff ? (32'd0 - mag) : mag;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == '0) |=> (state_ff == S_MUL))
      else $error("divide did not hand over to multiply");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff != 32'h8000_0000))
      else $error("step outside saturated range");

endmodule
